@@ sv/idt_pkg.sv @@
// Shared types and constants of the inertia dynamometer torque and power unit.
// Used by the controller, the datapath and the top level.
package idt_pkg;

  localparam int TIME_WIDTH_DEF = 40;
  localparam int FRAC_BITS_DEF  = 16;

  localparam logic [63:0] W_NUM   = 64'd26986075410000000;  // 2*pi*1e6, Q32
  localparam logic [63:0] RPM_NUM = 64'd15360000000;        // 60e6 * 256
  localparam logic [63:0] SPD_K   = 64'd2698607541000000;   // 200000*pi, Q32

  localparam logic [1:0] FLT_OK      = 2'd0;
  localparam logic [1:0] FLT_ZERO_DT = 2'd1;
  localparam logic [1:0] FLT_ZERO_TQ = 2'd2;

  localparam logic [7:0] CFG_INERTIA = 8'd0;
  localparam logic [7:0] CFG_DEAD    = 8'd1;
  localparam logic [7:0] CFG_VCORR   = 8'd2;
  localparam logic [7:0] CFG_FLOW    = 8'd3;

  typedef enum logic [3:0] {
    OP_RPM   = 4'd0,
    OP_GEAR  = 4'd1,
    OP_WA    = 4'd2,
    OP_WB    = 4'd3,
    OP_ALPHA = 4'd4,
    OP_TQ    = 4'd5,
    OP_PW    = 4'd6,
    OP_N     = 4'd7,
    OP_D     = 4'd8,
    OP_S     = 4'd9
  } op_t;

  typedef struct packed {
    logic       take;
    logic       start;
    logic       store;
    logic       emit;
    op_t        op;
    logic [1:0] fault;
  } cmd_t;

  typedef struct packed {
    logic produce;
    logic zero_dt;
    logic done;
    logic q_zero;
    logic out_free;
  } stat_t;

  function automatic logic [31:0] sat_s32(input logic [63:0] mag, input logic neg);
    logic [63:0] m;
    begin
      if (neg) begin
        m = (mag > 64'h80000000) ? 64'h80000000 : mag;
        sat_s32 = 32'(64'd0 - m);
      end else begin
        sat_s32 = (mag > 64'h7FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
      end
    end
  endfunction

  function automatic logic [39:0] sat_s40(input logic [63:0] mag, input logic neg);
    logic [63:0] m;
    begin
      if (neg) begin
        m = (mag > 64'h8000000000) ? 64'h8000000000 : mag;
        sat_s40 = 40'(64'd0 - m);
      end else begin
        sat_s40 = (mag > 64'h7FFFFFFFFF) ? 40'h7FFFFFFFFF : mag[39:0];
      end
    end
  endfunction

endpackage

@@ sv/idt_muldiv.sv @@
// Iterative unit for floor(a*b/c) over a 128-bit product, saturated to 2^64-1.
// Four 32x32 partial products and a check step, then 64 restoring divide steps unless the check saturates.
module idt_muldiv (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  input  logic [63:0] c,
  output logic        done,
  output logic [63:0] q
);
  typedef enum logic [2:0] {
    PH_MUL = 3'b001,
    PH_CHK = 3'b010,
    PH_DIV = 3'b100
  } phase_t;

  phase_t       phase_r;
  logic         busy_r, done_r;
  logic [5:0]   cnt_r;
  logic [63:0]  a_r, b_r, c_r, q_r;
  logic [127:0] acc_r;
  logic [31:0]  pa, pb;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [63:0]  hi2;
  logic         ge;

  always_comb begin
    case (cnt_r[1:0])
      2'd0: begin pa = a_r[31:0];  pb = b_r[31:0];  end
      2'd1: begin pa = a_r[31:0];  pb = b_r[63:32]; end
      2'd2: begin pa = a_r[63:32]; pb = b_r[31:0];  end
      default: begin pa = a_r[63:32]; pb = b_r[63:32]; end
    endcase
    pp = 64'(pa) * 64'(pb);
    case (cnt_r[1:0])
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
    hi2 = {acc_r[126:64], acc_r[63]};
    ge  = acc_r[127] || (hi2 >= c_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      phase_r <= PH_MUL;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r  <= 1'b1;
        phase_r <= PH_MUL;
        cnt_r   <= '0;
      end else if (busy_r) begin
        case (phase_r)
          PH_MUL: begin
            cnt_r <= cnt_r + 6'd1;
            if (cnt_r[1:0] == 2'd3) phase_r <= PH_CHK;
          end
          PH_CHK: begin
            cnt_r <= '0;
            if (c_r == 64'd0 || acc_r[127:64] >= c_r) begin
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end else begin
              phase_r <= PH_DIV;
            end
          end
          PH_DIV: begin
            cnt_r <= cnt_r + 6'd1;
            if (cnt_r == 6'd63) begin
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end
          end
          default: phase_r <= PH_MUL;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= a;
      b_r   <= b;
      c_r   <= c;
      acc_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      case (phase_r)
        PH_MUL: acc_r <= acc_r + pp_sh;
        PH_CHK: if (c_r == 64'd0 || acc_r[127:64] >= c_r) q_r <= '1;
        PH_DIV: begin
          acc_r <= {(ge ? hi2 - c_r : hi2), acc_r[62:0], 1'b0};
          q_r   <= {q_r[62:0], ge};
        end
        default: q_r <= q_r;
      endcase
    end
  end

  assign done = done_r;
  assign q    = q_r;
endmodule

@@ sv/idt_dpath.sv @@
// Datapath: configuration, tick and engine state, operand selection, result store
// and output register. Depends on idt_pkg and idt_muldiv.
module idt_dpath #(
  parameter int TIME_WIDTH = idt_pkg::TIME_WIDTH_DEF,
  parameter int FRAC_BITS  = idt_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  idt_pkg::cmd_t cmd,
  output idt_pkg::stat_t st,
  input  logic          in_tuser,
  input  logic [87:0]   in_tdata,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [159:0]  out_tdata,
  output logic [1:0]    out_tuser,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [7:0]    cfg_index,
  input  logic [31:0]   cfg_data
);
  import idt_pkg::*;

  logic [31:0] inertia_r, flow_r;
  logic [15:0] dead_r, vcorr_r;
  logic [TIME_WIDTH-1:0] older_r, last_r, t_in, da_r, db_r, sp_r;
  logic [1:0]  seen_r;
  logic [15:0] pw_h_r, rpm_h_r;
  logic [14:0] mv_h_r;
  logic signed [35:0] ti_nxt, ti_r;
  logic [35:0] tmag;
  logic [63:0] rpm_r, gear_r, wa_r, wb_r, alpha_r, tq_r, pwr_r, n_r, d_r, s_r;
  logic [63:0] da64, db64, sp64, dw, op_a, op_b, op_c, q;
  logic        aneg, tneg, done;
  logic        out_valid_r;
  logic [159:0] out_data_r, out_data_nxt;
  logic [1:0]  out_user_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inertia_r <= 32'd16777216;
      dead_r    <= '0;
      vcorr_r   <= '0;
      flow_r    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_INERTIA: inertia_r <= cfg_data;
        CFG_DEAD:    dead_r    <= cfg_data[15:0];
        CFG_VCORR:   vcorr_r   <= cfg_data[15:0];
        CFG_FLOW:    flow_r    <= cfg_data;
        default:     ;
      endcase
    end
  end

  assign t_in = TIME_WIDTH'(in_tdata[39:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      older_r <= '0;
      last_r  <= '0;
      seen_r  <= '0;
      pw_h_r  <= '0;
      rpm_h_r <= '0;
      mv_h_r  <= '0;
    end else if (cmd.take) begin
      if (!in_tuser) begin
        pw_h_r  <= in_tdata[55:40];
        rpm_h_r <= in_tdata[71:56];
        mv_h_r  <= in_tdata[86:72];
      end else begin
        older_r <= last_r;
        last_r  <= t_in;
        if (seen_r != 2'd2) seen_r <= seen_r + 2'd1;
      end
    end
  end

  // Intervals for the result, modulo the time width
  always_ff @(posedge clk) begin
    if (cmd.take && in_tuser) begin
      da_r <= last_r - older_r;
      db_r <= t_in - last_r;
      sp_r <= t_in - older_r;
    end
  end

  assign st.produce = in_tuser && (seen_r == 2'd2);
  assign st.zero_dt = (da_r == '0) || (db_r == '0) || (sp_r == '0);

  // Injection time in ns, signed
  always_comb begin
    ti_nxt = $signed({20'd0, pw_h_r}) * 36'sd1000
           - $signed({20'd0, dead_r}) * 36'sd1000
           - $signed({20'd0, vcorr_r}) * (36'sd13200 - $signed({21'd0, mv_h_r}));
  end

  always_ff @(posedge clk) ti_r <= ti_nxt;

  assign tneg = ti_r[35];
  assign tmag = tneg ? 36'(-ti_r) : 36'(ti_r);
  assign aneg = wb_r < wa_r;
  assign dw   = aneg ? wa_r - wb_r : wb_r - wa_r;
  assign da64 = 64'(da_r);
  assign db64 = 64'(db_r);
  assign sp64 = 64'(sp_r);

  always_comb begin
    case (cmd.op)
      OP_RPM:   begin op_a = RPM_NUM; op_b = 64'd1; op_c = db64; end
      OP_GEAR:  begin op_a = 64'(rpm_h_r) << FRAC_BITS; op_b = db64; op_c = 64'd60000000; end
      OP_WA:    begin op_a = W_NUM; op_b = 64'd1; op_c = da64; end
      OP_WB:    begin op_a = W_NUM; op_b = 64'd1; op_c = db64; end
      OP_ALPHA: begin op_a = dw; op_b = 64'd2000000; op_c = sp64; end
      OP_TQ:    begin op_a = 64'(inertia_r); op_b = alpha_r;
                      op_c = 64'd1 << (56 - FRAC_BITS); end
      OP_PW:    begin op_a = tq_r; op_b = wb_r; op_c = 64'd1 << (FRAC_BITS + 24); end
      OP_N:     begin op_a = 64'(flow_r) * 64'd3; op_b = 64'(tmag); op_c = 64'd1000; end
      OP_D:     begin op_a = tq_r; op_b = SPD_K; op_c = 64'd1 << 32; end
      OP_S:     begin op_a = n_r; op_b = 64'd1 << (2 * FRAC_BITS - 16); op_c = d_r; end
      default:  begin op_a = '0; op_b = '0; op_c = '0; end
    endcase
  end

  idt_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.start),
    .a     (op_a),
    .b     (op_b),
    .c     (op_c),
    .done  (done),
    .q     (q)
  );

  assign st.done   = done;
  assign st.q_zero = (q == 64'd0);

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      case (cmd.op)
        OP_RPM:   rpm_r   <= q;
        OP_GEAR:  gear_r  <= q;
        OP_WA:    wa_r    <= q;
        OP_WB:    wb_r    <= q;
        OP_ALPHA: alpha_r <= q;
        OP_TQ:    tq_r    <= q;
        OP_PW:    pwr_r   <= q;
        OP_N:     n_r     <= q;
        OP_D:     d_r     <= q;
        OP_S:     s_r     <= q;
        default:  ;
      endcase
    end
  end

  assign st.out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    out_data_nxt = '0;
    if (cmd.fault != FLT_ZERO_DT) begin
      out_data_nxt[31:0]    = (rpm_r > 64'hFFFFFFFF) ? 32'hFFFFFFFF : rpm_r[31:0];
      out_data_nxt[159:136] = (gear_r > 64'hFFFFFF) ? 24'hFFFFFF : gear_r[23:0];
    end
    if (cmd.fault == FLT_OK) begin
      out_data_nxt[63:32]   = sat_s32(tq_r, aneg);
      out_data_nxt[103:64]  = sat_s40(pwr_r, aneg);
      out_data_nxt[135:104] = sat_s32(s_r, (tneg != aneg) && (s_r != 64'd0));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_user_r <= cmd.fault;
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
endmodule

@@ sv/idt_ctrl.sv @@
// Controller: accepts items and sequences the ten multiply-divide operations.
// Depends on idt_pkg; drives the datapath through cmd_t and reads stat_t.
module idt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  idt_pkg::stat_t st,
  output idt_pkg::cmd_t  cmd
);
  import idt_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_START = 5'b00100,
    S_WAIT  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t     state_r, state_nxt;
  op_t        op_r, op_nxt;
  logic [1:0] fault_r, fault_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    fault_nxt = fault_r;
    cmd       = '0;
    cmd.op    = op_r;
    cmd.fault = fault_r;
    case (state_r)
      S_IDLE: begin
        cmd.take = in_tvalid;
        if (in_tvalid && st.produce) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (st.zero_dt) begin
          fault_nxt = FLT_ZERO_DT;
          state_nxt = S_EMIT;
        end else begin
          fault_nxt = FLT_OK;
          op_nxt    = OP_RPM;
          state_nxt = S_START;
        end
      end
      S_START: begin
        cmd.start = 1'b1;
        state_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (st.done) begin
          cmd.store = 1'b1;
          if (op_r == OP_TQ && st.q_zero) begin
            fault_nxt = FLT_ZERO_TQ;
            state_nxt = S_EMIT;
          end else if (op_r == OP_S) begin
            state_nxt = S_EMIT;
          end else begin
            op_nxt    = op_t'(op_r + 4'd1);
            state_nxt = S_START;
          end
        end
      end
      S_EMIT: begin
        // hold until the output register can take the result
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_RPM;
      fault_r <= FLT_OK;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      fault_r <= fault_nxt;
    end
  end
endmodule

@@ sv/inertia_dyno_torque_power_unit.sv @@
// Top level of the inertia dynamometer torque and power unit.
// Depends on idt_pkg, idt_ctrl and idt_dpath.
//
// in_*  : one item per transfer. in_tuser is 0 for an engine sample, 1 for a
//         roller tick. Samples only latch pulse width, engine rpm and battery
//         voltage; ticks from the third on each give one result on out_*.
// out_* : roller rpm, torque, power, specific power, gear ratio; fault on
//         out_tuser. A zero interval gives fault 1 with all data zero; zero
//         torque gives fault 2 with torque, power and specific power zero.
// cfg_* : register writes, always ready; index 0 inertia, 1 dead time,
//         2 voltage correction, 3 injector flow. Other indexes are ignored.
// Processing: a sample or an early tick is only latched. A producing tick runs
// ten multiply-divide operations in turn on one shared unit, each a start, four
// partial products, a check, 64 divide steps and a store, plus the transfer,
// check and emit; an operation ends at its check when it saturates early, zero
// torque stops after six operations and a zero interval runs none. The next
// item is taken once the result sits in the output register, which holds it
// while out_tready is low; a further result waits for that register to drain.
// Reset clears tick history and latched sample and loads register defaults.
module inertia_dyno_torque_power_unit #(
  parameter int TIME_WIDTH = idt_pkg::TIME_WIDTH_DEF,
  parameter int FRAC_BITS  = idt_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [87:0]  in_tdata,   // time_us[39:0], pulse_width_us, engine_rpm, battery_mv
  input  logic         in_tuser,   // func
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [159:0] out_tdata,  // roller_rpm_q8, torque_q16, power_q8,
                                   // specific_power_q16, gear_ratio_q16
  output logic [1:0]   out_tuser,  // fault
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import idt_pkg::*;

  cmd_t  cmd;
  stat_t st;

  idt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  idt_dpath #(
    .TIME_WIDTH (TIME_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  a_fault_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser != 2'd3)
    else $error("fault code out of range");

  a_zero_dt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == FLT_ZERO_DT) |-> out_tdata == '0)
    else $error("zero interval result carries data");

  a_zero_tq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == FLT_ZERO_TQ) |-> out_tdata[135:32] == '0)
    else $error("zero torque result carries torque terms");
endmodule
